/* design/pedtf_pkg.sv */
package pedtf_pkg;

   localparam int NUM_ELEMENTS = 1024;
   localparam int TIME_BITS    = 48;

   localparam int ELEM_BITS    = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
   localparam int ELEMENT_W    = 10;
   localparam int PULSE_TIME_W = 48;
   localparam int RUN_W        = 16;
   localparam int DEAD_TIME_W  = 32;
   localparam int BUF_SIZE_W   = 8;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int SUM_W        = ((TIME_BITS > DEAD_TIME_W) ? TIME_BITS : DEAD_TIME_W) + 1;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [BUF_SIZE_W-1:0] count_type;
   typedef logic [ELEM_BITS-1:0]  elem_index_type;

   localparam time_type TIME_MAX = '1;

   typedef struct packed {
      time_type  rebirth;
      count_type count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_EVAL,
      ST_WRITE
   } state_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEAD_TIME   = 8'd0,
      REG_PARALYSABLE = 8'd1,
      REG_BUFFER_SIZE = 8'd2,
      REG_BUFFER_MODE = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic read;
      logic eval;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic run_new;
      logic clear_last;
      logic rsp_stall;
   } status_type;

endpackage

/* design/pedtf_if.sv */
interface pedtf_req_if;
   logic                              valid;
   logic                              ready;
   logic [pedtf_pkg::ELEMENT_W-1:0]    element_id;
   logic [pedtf_pkg::PULSE_TIME_W-1:0] pulse_time;
   logic                              has_energy;
   logic [pedtf_pkg::RUN_W-1:0]        run_number;

   modport source (output valid, element_id, pulse_time, has_energy, run_number,
                   input ready);
   modport sink (input valid, element_id, pulse_time, has_energy, run_number,
                 output ready);
   modport monitor (input valid, ready, element_id, pulse_time, has_energy, run_number);
endinterface

interface pedtf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              passed;
   logic [pedtf_pkg::ELEMENT_W-1:0]    element_out;
   logic [pedtf_pkg::PULSE_TIME_W-1:0] time_out;

   modport source (output valid, passed, element_out, time_out, input ready);
   modport sink (input valid, passed, element_out, time_out, output ready);
   modport monitor (input valid, ready, passed, element_out, time_out);
endinterface

interface pedtf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pedtf_pkg::CSR_INDEX_W-1:0] index;
   logic [pedtf_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

/* design/per_element_dead_time_filter_core.sv */
// Channel   Direction  Carries
// req_bus   in         element_id, pulse_time, has_energy, run_number
// rsp_bus   out        passed, element_out, time_out
// csr_bus   in         index, data (dead_time, paralysable, buffer_size, buffer_mode)
//
// Each pulse passes from its accepting beat through the read, evaluate and write-back
// states, the read-modify-write of one element entry in the single-port element table.
// The first pulse after reset and every pulse with a new run number first sweep the
// table clear, one entry a cycle, before the read of that pulse's element entry.
// Reset is synchronous; it clears the configuration and the run tracking.
// A new pulse is accepted while a result waits; a stalled result beat holds only the
// write-back cycle of the following pulse.
module per_element_dead_time_filter_core (
   input logic         clock,
   input logic         reset,
   pedtf_req_if.sink   req_bus,
   pedtf_rsp_if.source rsp_bus,
   pedtf_csr_if.sink   csr_bus
);
   import pedtf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ctrl_ready;

   assign req_bus.ready = ctrl_ready;

   pedtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pedtf_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .status  (status)
   );

endmodule

/* design/pedtf_ctrl.sv */
module pedtf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pedtf_pkg::status_type status,
   output pedtf_pkg::cmd_type    cmd
);
   import pedtf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.run_new ? ST_CLEAR : ST_READ;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!status.rsp_stall) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/pedtf_dp.sv */
module pedtf_dp (
   input  logic               clock,
   input  logic               reset,
   pedtf_req_if.sink          req_bus,
   pedtf_rsp_if.source        rsp_bus,
   pedtf_csr_if.sink          csr_bus,
   input  pedtf_pkg::cmd_type cmd,
   output pedtf_pkg::status_type status
);
   import pedtf_pkg::*;

   // Configuration registers.
   logic [DEAD_TIME_W-1:0] dead_time_ff;
   logic                   paralysable_ff;
   count_type              buffer_size_ff;
   logic                   buffer_mode_ff;

   // Run tracking.
   logic [RUN_W-1:0] last_run_ff;
   logic             run_seen_ff;

   // Captured pulse.
   logic [ELEMENT_W-1:0] elem_ff;
   time_type             time_ff;
   logic                 energy_ff;

   // Element table and its sweep counter.
   entry_type      mem [NUM_ELEMENTS];
   entry_type      rd_data_ff;
   elem_index_type clr_cnt_ff;
   elem_index_type clr_cnt_in;

   // Evaluation stage.
   logic             live_ff;
   logic [SUM_W-1:0] sum_ff;

   // Result register.
   logic                    rsp_valid_ff;
   logic                    rsp_passed_ff;
   logic [ELEMENT_W-1:0]    rsp_element_ff;
   logic [PULSE_TIME_W-1:0] rsp_time_ff;

   logic [63:0]    t_ext;
   logic [31:0]    elem_ext;
   elem_index_type elem_idx;
   logic           in_range;
   logic           has_buffer;
   count_type      cnt_inc;
   time_type       rebirth_sat;
   logic           pass;
   logic           entry_we;
   entry_type      entry_new;
   logic           mem_we;
   elem_index_type mem_addr;
   entry_type      mem_wdata;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_time_ff   <= '0;
         paralysable_ff <= 1'b0;
         buffer_size_ff <= '0;
         buffer_mode_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_DEAD_TIME:   dead_time_ff   <= csr_bus.data[DEAD_TIME_W-1:0];
            REG_PARALYSABLE: paralysable_ff <= csr_bus.data[0];
            REG_BUFFER_SIZE: buffer_size_ff <= csr_bus.data[BUF_SIZE_W-1:0];
            REG_BUFFER_MODE: buffer_mode_ff <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   assign status.run_new    = !run_seen_ff || (req_bus.run_number != last_run_ff);
   assign status.clear_last = (32'(clr_cnt_ff) == 32'(NUM_ELEMENTS - 1));
   assign status.rsp_stall  = rsp_valid_ff && !rsp_bus.ready;

   assign t_ext = 64'(req_bus.pulse_time);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_seen_ff <= 1'b0;
      end else if (cmd.capture) begin
         run_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         last_run_ff <= req_bus.run_number;
         elem_ff     <= req_bus.element_id;
         time_ff     <= t_ext[TIME_BITS-1:0];
         energy_ff   <= req_bus.has_energy;
      end
   end

   assign clr_cnt_in = status.clear_last ? '0 : clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign elem_ext = 32'(elem_ff);
   assign elem_idx = elem_ext[ELEM_BITS-1:0];
   assign in_range = elem_ext < 32'(NUM_ELEMENTS);

   assign mem_we    = cmd.clear_step || (cmd.write && entry_we);
   assign mem_addr  = cmd.clear_step ? clr_cnt_ff : elem_idx;
   assign mem_wdata = cmd.clear_step ? '0 : entry_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[elem_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         live_ff <= time_ff >= rd_data_ff.rebirth;
         sum_ff  <= SUM_W'(time_ff) + SUM_W'(dead_time_ff);
      end
   end

   assign has_buffer  = buffer_size_ff > count_type'(1);
   assign cnt_inc     = rd_data_ff.count + 1'b1;
   assign rebirth_sat = (sum_ff > SUM_W'(TIME_MAX)) ? TIME_MAX : sum_ff[TIME_BITS-1:0];

   always_comb begin
      pass      = 1'b0;
      entry_we  = 1'b0;
      entry_new = rd_data_ff;
      if (energy_ff && in_range) begin
         entry_we = 1'b1;
         if (live_ff) begin
            pass = 1'b1;
            if (has_buffer) begin
               if (cnt_inc == buffer_size_ff) begin
                  entry_new.rebirth = rebirth_sat;
                  entry_new.count   = '0;
               end else begin
                  entry_new.count = cnt_inc;
               end
            end else begin
               entry_new.rebirth = rebirth_sat;
            end
         end else if (has_buffer && buffer_mode_ff) begin
            if (rd_data_ff.count < buffer_size_ff - 1'b1) begin
               entry_new.count = cnt_inc;
               pass            = 1'b1;
            end
         end else if (paralysable_ff && !has_buffer) begin
            entry_new.rebirth = rebirth_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_passed_ff  <= pass;
         rsp_element_ff <= elem_ff;
         rsp_time_ff    <= PULSE_TIME_W'(64'(time_ff));
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.passed      = rsp_passed_ff;
   assign rsp_bus.element_out = rsp_element_ff;
   assign rsp_bus.time_out    = rsp_time_ff;

endmodule

/* design/pedtf_checker.sv */
module pedtf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_passed,
   input logic [pedtf_pkg::ELEMENT_W-1:0]    rsp_element_out,
   input logic [pedtf_pkg::PULSE_TIME_W-1:0] rsp_time_out
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_valid)
      else $error("Result beat dropped before it was taken.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> $stable(rsp_passed) && $stable(rsp_element_out)
                    && $stable(rsp_time_out))
      else $error("Stalled result beat changed.");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("Request accepted while a pulse is still in work.");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("Result appeared too soon after a request beat.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind per_element_dead_time_filter_core pedtf_checker u_pedtf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_passed      (rsp_bus.passed),
   .rsp_element_out (rsp_bus.element_out),
   .rsp_time_out    (rsp_bus.time_out)
);
